### src/bounded_positional_list_core_macros.svh
// Assertion macros for the bounded positional list core.
`ifndef BOUNDED_POSITIONAL_LIST_CORE_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define BPL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded positional list: assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define BPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded positional list: assertion failed");
`else
`define BPL_ASSERT_IMPL(label, ante, cons)
`define BPL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/bpl_pkg.sv
// Types and codes shared by the bounded positional list core and its cells.
package bpl_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_INSERT_AT  = 3'd4,
    ACT_ERASE_AT   = 3'd5,
    ACT_CLEAR      = 3'd6
  } bpl_action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } bpl_status_t;

  // Per-cycle command broadcast along the cell row.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } bpl_cell_op_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  position;
    logic [31:0] value;
  } bpl_in_beat_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic [4:0]  element_count;
    logic [1:0]  status;
  } bpl_out_beat_t;

endpackage

### src/bpl_cell.sv
// One list slot: holds an element and shifts toward or away from its neighbors.
module bpl_cell import bpl_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 4,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bpl_cell_op_t          op,
  input  logic [IW-1:0]         at,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_OPEN: begin
        // take the left neighbor behind the gap, the new value at the gap
        if (MY_IDX > at) begin
          data_nxt = left_data;
        end else if (MY_IDX == at) begin
          data_nxt = ins_data;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= at) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

### src/bounded_positional_list_core.sv
// Top level of the bounded positional list: request decode, cell row, result register.
//
// Keeps an ordered list of up to DEPTH elements of DATA_WIDTH bits in a row of
// cells, index 0 at the front. Each request beat on the in_ channel (in_valid,
// in_stall, in_beat) carries an action, a position and a value; it is taken at
// a clock edge where in_valid is high and in_stall is low. Every request yields
// exactly one result beat on the out_ channel: the popped value, the element
// count after the request and a status.
// The whole cell row shifts in parallel at the accepting edge and the result
// lands in the output register at that same edge.
// One request is taken per cycle while in_stall is low, since the cell row and
// the count register update together at the accepting edge.
// When the receiver raises out_stall, the result register holds its beat and
// in_stall is raised while a result is waiting, so no result is dropped.
// Reset (rst_n low, synchronous) empties the list and the output register;
// element contents are not cleared and are only read below the count.
module bounded_positional_list_core import bpl_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bpl_in_beat_t  in_beat,
  output logic          out_valid,
  input  logic          out_stall,
  output bpl_out_beat_t out_beat
);

`include "bounded_positional_list_core_macros.svh"

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  bpl_out_beat_t         out_beat_r;
  bpl_out_beat_t         out_beat_nxt;

  logic                  in_acc;
  logic                  full;
  logic                  empty;
  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       pos_ext;
  bpl_cell_op_t          op;
  bpl_cell_op_t          cell_op;
  logic [IW-1:0]         at;
  bpl_status_t           status;
  logic                  do_pop;
  logic [63:0]           val_wide;
  logic [63:0]           pop_wide;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign cnt_ext  = CMPW'(count_r);
  assign pos_ext  = CMPW'(in_beat.position);

  // request decode
  always_comb begin
    op        = CELL_HOLD;
    at        = '0;
    count_nxt = count_r;
    status    = ST_OK;
    do_pop    = 1'b0;
    case (in_beat.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op        = CELL_OPEN;
          at        = (in_beat.action == ACT_PUSH_FRONT) ? '0 : IW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op        = CELL_CLOSE;
          at        = (in_beat.action == ACT_POP_FRONT) ? '0 : IW'(count_r - CW'(1));
          count_nxt = count_r - CW'(1);
          do_pop    = 1'b1;
        end
      end
      ACT_INSERT_AT: begin
        if (empty) begin
          op        = CELL_OPEN;
          count_nxt = CW'(1);
        end else if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op        = CELL_OPEN;
          at        = IW'(in_beat.position);
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_ERASE_AT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          op        = CELL_CLOSE;
          at        = IW'(in_beat.position);
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign cell_op  = in_acc ? op : CELL_HOLD;
  assign val_wide = 64'(in_beat.value);
  assign ins_data = val_wide[DATA_WIDTH-1:0];
  assign pop_wide = 64'(cell_data[at]);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      bpl_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .IDX        (gi)
      ) u_cell (
        .clk        (clk),
        .op         (cell_op),
        .at         (at),
        .ins_data   (ins_data),
        .left_data  (left_d),
        .right_data (right_d),
        .data_out   (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    out_beat_nxt.popped_value  = do_pop ? pop_wide[31:0] : 32'd0;
    out_beat_nxt.element_count = 5'(count_nxt);
    out_beat_nxt.status        = status;
  end

  // hold the result beat while the receiver stalls
  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `BPL_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `BPL_ASSERT_NEXT(a_result_follows, in_acc, out_valid_r)
  `BPL_ASSERT_IMPL(a_count_matches, out_valid_r, out_beat_r.element_count == 5'(count_r))
  `BPL_ASSERT_IMPL(a_empty_pops_zero, out_valid_r && out_beat_r.status == ST_EMPTY,
                   out_beat_r.popped_value == 32'd0)

endmodule

### sim/tb_bounded_positional_list_core.sv
// Testbench for the bounded positional list core: directed steps, random list traffic, scoreboard.
module tb_bounded_positional_list_core;
  import bpl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_OPS = 1300;
  localparam int QUIET_TAIL = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct {
    bpl_in_beat_t  req;
    int unsigned   reps;
    bit            typed;
    bpl_out_beat_t want;
  } list_step_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bpl_in_beat_t  in_beat = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bpl_out_beat_t out_beat;

  // Shadow copy of the list contents and length.
  logic [31:0]   list_vals [LIST_DEPTH];
  int unsigned   list_len = 0;

  bpl_out_beat_t pending_results [$];
  list_step_t    directed_steps [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  bit            tail_quiet = 1'b0;

  bounded_positional_list_core #(
    .DEPTH(LIST_DEPTH),
    .DATA_WIDTH(32)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat)
  );

  always #5 clk = ~clk;

  function automatic void open_slot(int unsigned at, logic [31:0] v);
    for (int unsigned i = list_len; i > at; i--) list_vals[i] = list_vals[i - 1];
    list_vals[at] = v;
    list_len++;
  endfunction

  function automatic logic [31:0] close_slot(int unsigned at);
    logic [31:0] v;
    v = list_vals[at];
    for (int unsigned i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
    list_len--;
    return v;
  endfunction

  function automatic bpl_out_beat_t predict_list_op(bpl_in_beat_t req);
    bpl_out_beat_t res;
    int unsigned   pos;
    res = '0;
    res.status = ST_OK;
    pos = 32'(req.position);
    case (req.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (list_len >= LIST_DEPTH) res.status = ST_FULL;
        else open_slot((req.action == ACT_PUSH_FRONT) ? 0 : list_len, req.value);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.popped_value = close_slot((req.action == ACT_POP_FRONT) ? 0 : list_len - 1);
      end
      ACT_INSERT_AT: begin
        // Empty list takes the value at the front, whatever the position.
        if (list_len == 0) open_slot(0, req.value);
        else if (pos > list_len) res.status = ST_RANGE;
        else if (list_len >= LIST_DEPTH) res.status = ST_FULL;
        else open_slot(pos, req.value);
      end
      ACT_ERASE_AT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (pos >= list_len) res.status = ST_RANGE;
        else void'(close_slot(pos));
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    res.element_count = 5'(list_len);
    return res;
  endfunction

  function automatic void add_step(logic [2:0] act, logic [4:0] pos, logic [31:0] val,
                                   int unsigned reps, bit typed, logic [31:0] pop,
                                   logic [4:0] cnt, bpl_status_t st);
    list_step_t s;
    s.req.action = act;
    s.req.position = pos;
    s.req.value = val;
    s.reps = reps;
    s.typed = typed;
    s.want.popped_value = pop;
    s.want.element_count = cnt;
    s.want.status = st;
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic bpl_in_beat_t pick_list_op(bit growing);
    bpl_in_beat_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: r.value = '0;
      1: r.value = '1;
      default: r.value = $urandom;
    endcase
    r.position = 5'($urandom_range(0, 31));
    if (roll < 2) r.action = ACT_UNUSED;
    else if (roll < 5) r.action = ACT_CLEAR;
    else if ((roll < 68) == growing) begin
      case ($urandom_range(0, 2))
        0: r.action = ACT_PUSH_FRONT;
        1: r.action = ACT_PUSH_BACK;
        default: begin
          r.action = ACT_INSERT_AT;
          if ($urandom_range(0, 7) != 0) r.position = 5'($urandom_range(0, list_len));
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: r.action = ACT_POP_FRONT;
        1: r.action = ACT_POP_BACK;
        default: begin
          r.action = ACT_ERASE_AT;
          if (list_len != 0 && $urandom_range(0, 7) != 0)
            r.position = 5'($urandom_range(0, list_len - 1));
        end
      endcase
    end
    return r;
  endfunction

  function automatic void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
    mismatch_count++;
  endfunction

  task automatic send_request(bpl_in_beat_t req, bit typed, bpl_out_beat_t want, bit may_idle);
    bpl_out_beat_t predicted;
    if (may_idle && !tail_quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= req;
    do @(posedge clk); while (in_stall);
    predicted = predict_list_op(req);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  initial begin
    bpl_out_beat_t none;
    bpl_in_beat_t  req;
    bit            growing;
    bit            drained;
    int unsigned   sent;
    none = '0;
    growing = 1'b1;
    drained = 1'b0;
    sent = 0;

    add_step(ACT_POP_FRONT,  5'd0,  32'h0,        1, 1, 32'h0, 5'd0,  ST_EMPTY);
    add_step(ACT_POP_BACK,   5'd0,  32'h0,        1, 1, 32'h0, 5'd0,  ST_EMPTY);
    add_step(ACT_ERASE_AT,   5'd0,  32'h0,        1, 1, 32'h0, 5'd0,  ST_EMPTY);
    add_step(ACT_INSERT_AT,  5'd31, 32'hDEADBEEF, 1, 1, 32'h0, 5'd1,  ST_OK);
    add_step(ACT_PUSH_BACK,  5'd0,  32'hFFFFFFFF, 1, 1, 32'h0, 5'd2,  ST_OK);
    add_step(ACT_PUSH_FRONT, 5'd0,  32'h0,        1, 1, 32'h0, 5'd3,  ST_OK);
    add_step(ACT_INSERT_AT,  5'd3,  32'hA5A5A5A5, 1, 1, 32'h0, 5'd4,  ST_OK);
    add_step(ACT_INSERT_AT,  5'd5,  32'h11111111, 1, 1, 32'h0, 5'd4,  ST_RANGE);
    add_step(ACT_ERASE_AT,   5'd4,  32'h0,        1, 1, 32'h0, 5'd4,  ST_RANGE);
    add_step(ACT_INSERT_AT,  5'd0,  32'h5A5A5A5A, 1, 1, 32'h0, 5'd5,  ST_OK);
    add_step(ACT_ERASE_AT,   5'd31, 32'h0,        1, 1, 32'h0, 5'd5,  ST_RANGE);
    add_step(ACT_INSERT_AT,  5'd2,  32'h0F0F0F0F, 1, 0, 32'h0, 5'd0,  ST_OK);
    add_step(ACT_PUSH_BACK,  5'd0,  32'h12345678, 10, 0, 32'h0, 5'd0, ST_OK);
    add_step(ACT_PUSH_FRONT, 5'd0,  32'h22222222, 1, 1, 32'h0, 5'd16, ST_FULL);
    add_step(ACT_PUSH_BACK,  5'd0,  32'h33333333, 1, 1, 32'h0, 5'd16, ST_FULL);
    add_step(ACT_INSERT_AT,  5'd16, 32'h44444444, 1, 1, 32'h0, 5'd16, ST_FULL);
    add_step(ACT_INSERT_AT,  5'd17, 32'h55555555, 1, 1, 32'h0, 5'd16, ST_RANGE);
    add_step(ACT_ERASE_AT,   5'd2,  32'h0,        1, 1, 32'h0, 5'd15, ST_OK);
    add_step(ACT_POP_FRONT,  5'd0,  32'h0,        1, 0, 32'h0, 5'd0,  ST_OK);
    add_step(ACT_POP_BACK,   5'd0,  32'h0,        1, 0, 32'h0, 5'd0,  ST_OK);
    add_step(ACT_UNUSED,     5'd9,  32'h66666666, 1, 0, 32'h0, 5'd0,  ST_OK);
    add_step(ACT_CLEAR,      5'd0,  32'h0,        1, 1, 32'h0, 5'd0,  ST_OK);
    add_step(ACT_CLEAR,      5'd0,  32'h0,        1, 1, 32'h0, 5'd0,  ST_OK);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i])
      repeat (directed_steps[i].reps)
        send_request(directed_steps[i].req, directed_steps[i].typed,
                     directed_steps[i].want, 1'b1);

    while (sent < RANDOM_OPS) begin
      // Swing the list between empty and full so both ends get exercised.
      if (list_len == LIST_DEPTH) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      if (!drained && sent == RANDOM_OPS / 2) begin
        // Hold off the sender until every outstanding result is back.
        drained = 1'b1;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (sent >= RANDOM_OPS - QUIET_TAIL) tail_quiet = 1'b1;
      req = pick_list_op(growing);
      send_request(req, 1'b0, none, (sent % 200) >= 40);
      if (req.action != ACT_UNUSED) sent++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure in bursts, with calm windows and a calm tail.
  always @(posedge clk) begin
    if (tail_quiet || cycle_count[8:6] == 3'd0) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    bpl_out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested beat popped_value", 32'h0, out_beat.popped_value);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_beat.popped_value !== want.popped_value)
          report_mismatch("popped_value", want.popped_value, out_beat.popped_value);
        if (out_beat.element_count !== want.element_count)
          report_mismatch("element_count", 32'(want.element_count),
                          32'(out_beat.element_count));
        if (out_beat.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_beat.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
